/* rtl/sha1_byte_stream_hasher_assert.svh */
// Assertion macros used by the checker file of the SHA-1 byte stream hasher.
// Each macro samples on the rising edge of aclk and is quiet while aresetn is low.
`ifndef SHA1_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA1_BYTE_STREAM_HASHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHA1BSH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHA1BSH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/sha1bsh_pkg.sv */
package sha1bsh_pkg;

    localparam int WORD_W      = 32;
    localparam int BLOCK_WORDS = 16;
    localparam int HASH_WORDS  = 5;
    localparam int ROUNDS      = 80;
    localparam int ROUND_W     = 7;
    localparam int IDX_W       = 3;
    localparam int FILL_W      = 6;
    localparam int WIDX_W      = 4;

    typedef logic [WORD_W-1:0] word_t;

    localparam logic [FILL_W-1:0]  FILL_LAST     = 6'd63;
    localparam logic [FILL_W-1:0]  LONG_TAIL_MIN = 6'd56;
    localparam logic [7:0]         PAD_BYTE      = 8'h80;
    localparam logic [ROUND_W-1:0] ROUND_LAST    = 7'(ROUNDS - 1);
    localparam logic [IDX_W-1:0]   OUT_LAST      = 3'(HASH_WORDS - 1);

    localparam logic FUNC_ABSORB = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    localparam word_t H_INIT [HASH_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam word_t K_00_19 = 32'h5A827999;
    localparam word_t K_20_39 = 32'h6ED9EBA1;
    localparam word_t K_40_59 = 32'h8F1BBCDC;
    localparam word_t K_60_79 = 32'hCA62C1D6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PAD_NONE,
        PAD_TAIL,
        PAD_LEN
    } pad_mode_t;

    typedef struct packed {
        logic               write_byte;
        logic               load_hash;
        logic               load_block;
        pad_mode_t          pad_mode;
        logic               round_en;
        logic [ROUND_W-1:0] round_idx;
        logic               fold;
        logic               commit;
        logic               out_load;
        logic [IDX_W-1:0]   out_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic fill_last;
        logic long_tail;
        logic out_free;
    } dp_status_t;

    function automatic word_t rotl1(input word_t x);
        return {x[WORD_W-2:0], x[WORD_W-1]};
    endfunction

    function automatic word_t rotl5(input word_t x);
        return {x[WORD_W-6:0], x[WORD_W-1:WORD_W-5]};
    endfunction

    function automatic word_t rotl30(input word_t x);
        return {x[1:0], x[WORD_W-1:2]};
    endfunction

    function automatic word_t round_f(input logic [ROUND_W-1:0] t,
                                      input word_t b, input word_t c, input word_t d);
        word_t f;
        if (t < 7'd20) begin
            f = (b & c) | (~b & d);
        end else if (t < 7'd40) begin
            f = b ^ c ^ d;
        end else if (t < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    function automatic word_t round_k(input logic [ROUND_W-1:0] t);
        word_t k;
        if (t < 7'd20) begin
            k = K_00_19;
        end else if (t < 7'd40) begin
            k = K_20_39;
        end else if (t < 7'd60) begin
            k = K_40_59;
        end else begin
            k = K_60_79;
        end
        return k;
    endfunction

endpackage

/* rtl/sha1bsh_ctrl.sv */
module sha1bsh_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_func,
    output logic                    s_ready,
    input  sha1bsh_pkg::dp_status_t status,
    output sha1bsh_pkg::dp_cmd_t    cmd
);
    import sha1bsh_pkg::*;

    state_t             state_reg, state_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic [IDX_W-1:0]   emit_idx_reg, emit_idx_next;
    logic               fin_reg, fin_next;
    logic               second_reg, second_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            round_reg    <= '0;
            emit_idx_reg <= '0;
            fin_reg      <= 1'b0;
            second_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            round_reg    <= round_next;
            emit_idx_reg <= emit_idx_next;
            fin_reg      <= fin_next;
            second_reg   <= second_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && (s_func == FUNC_FINISH || status.fill_last)) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                if (round_reg == ROUND_LAST) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (!fin_reg) begin
                    state_next = ST_IDLE;
                end else if (!second_reg && status.long_tail) begin
                    state_next = ST_LOAD;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free && emit_idx_reg == OUT_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands and counters.
    always_comb begin
        cmd           = '0;
        cmd.pad_mode  = PAD_NONE;
        s_ready       = 1'b0;
        round_next    = round_reg;
        emit_idx_next = emit_idx_reg;
        fin_next      = fin_reg;
        second_next   = second_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_func == FUNC_FINISH) begin
                        cmd.load_hash = 1'b1;
                        fin_next      = 1'b1;
                        second_next   = 1'b0;
                    end else begin
                        cmd.write_byte = 1'b1;
                        cmd.load_hash  = status.fill_last;
                        fin_next       = 1'b0;
                        second_next    = 1'b0;
                    end
                end
            end
            ST_LOAD: begin
                cmd.load_block = 1'b1;
                if (!fin_reg) begin
                    cmd.pad_mode = PAD_NONE;
                end else if (second_reg) begin
                    cmd.pad_mode = PAD_LEN;
                end else begin
                    cmd.pad_mode = PAD_TAIL;
                end
                round_next = '0;
            end
            ST_ROUND: begin
                cmd.round_en  = 1'b1;
                cmd.round_idx = round_reg;
                round_next    = round_reg + 7'd1;
            end
            ST_FOLD: begin
                cmd.fold   = 1'b1;
                cmd.commit = !fin_reg;
                if (fin_reg && !second_reg && status.long_tail) begin
                    second_next = 1'b1;
                end
                emit_idx_next = '0;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_idx   = emit_idx_reg;
                    emit_idx_next = emit_idx_reg + 3'd1;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/sha1bsh_dp.sv */
module sha1bsh_dp (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [7:0]              s_data_byte,
    input  sha1bsh_pkg::dp_cmd_t    cmd,
    output sha1bsh_pkg::dp_status_t status,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [31:0]             m_digest_word,
    output logic [2:0]              m_word_index,
    output logic                    m_last_word
);
    import sha1bsh_pkg::*;

    logic [FILL_W-1:0] fill_reg;
    word_t             total_reg;
    word_t             h_reg   [HASH_WORDS];
    word_t             hw_reg  [HASH_WORDS];
    word_t             rv_reg  [HASH_WORDS];
    word_t             buf_reg [BLOCK_WORDS];
    word_t             win_reg [BLOCK_WORDS];
    logic              m_valid_reg;
    word_t             m_word_reg;
    logic [IDX_W-1:0]  m_index_reg;
    logic              m_last_reg;

    word_t             blk     [BLOCK_WORDS];
    word_t             tail_word;
    word_t             len_word;
    word_t             round_sum;
    word_t             sched_next;
    logic [WIDX_W-1:0] tail_idx;
    logic [1:0]        tail_lane;
    logic              long_tail;

    assign tail_idx  = fill_reg[FILL_W-1:2];
    assign tail_lane = fill_reg[1:0];
    assign long_tail = fill_reg >= LONG_TAIL_MIN;
    assign len_word  = {total_reg[WORD_W-4:0], 3'b000};

    assign status.fill_last = fill_reg == FILL_LAST;
    assign status.long_tail = long_tail;
    assign status.out_free  = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_digest_word = m_word_reg;
    assign m_word_index  = m_index_reg;
    assign m_last_word   = m_last_reg;

    // The word holding the end of the message: kept bytes, then the pad byte, then zeros.
    always_comb begin
        tail_word = '0;
        for (int l = 0; l < 4; l++) begin
            if (2'(l) < tail_lane) begin
                tail_word[WORD_W-1-8*l -: 8] = buf_reg[tail_idx][WORD_W-1-8*l -: 8];
            end else if (2'(l) == tail_lane) begin
                tail_word[WORD_W-1-8*l -: 8] = PAD_BYTE;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < BLOCK_WORDS; i++) begin
            unique case (cmd.pad_mode)
                PAD_NONE: begin
                    blk[i] = buf_reg[i];
                end
                PAD_TAIL: begin
                    if (4'(i) < tail_idx) begin
                        blk[i] = buf_reg[i];
                    end else if (4'(i) == tail_idx) begin
                        blk[i] = tail_word;
                    end else begin
                        blk[i] = '0;
                    end
                    if (i == BLOCK_WORDS - 1 && !long_tail) begin
                        blk[i] = len_word;
                    end
                end
                PAD_LEN: begin
                    blk[i] = (i == BLOCK_WORDS - 1) ? len_word : '0;
                end
                default: begin
                    blk[i] = '0;
                end
            endcase
        end
    end

    assign round_sum = rotl5(rv_reg[0])
                     + round_f(cmd.round_idx, rv_reg[1], rv_reg[2], rv_reg[3])
                     + rv_reg[4] + win_reg[0] + round_k(cmd.round_idx);
    assign sched_next = rotl1(win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < HASH_WORDS; i++) begin
                h_reg[i] <= H_INIT[i];
            end
        end else begin
            if (cmd.write_byte) begin
                fill_reg  <= fill_reg + 6'd1;
                total_reg <= total_reg + 32'd1;
            end
            if (cmd.fold && cmd.commit) begin
                for (int i = 0; i < HASH_WORDS; i++) begin
                    h_reg[i] <= hw_reg[i] + rv_reg[i];
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_byte) begin
            buf_reg[tail_idx][{~tail_lane, 3'b000} +: 8] <= s_data_byte;
        end
        if (cmd.load_hash) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                hw_reg[i] <= h_reg[i];
            end
        end else if (cmd.fold) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                hw_reg[i] <= hw_reg[i] + rv_reg[i];
            end
        end
        if (cmd.load_block) begin
            for (int i = 0; i < BLOCK_WORDS; i++) begin
                win_reg[i] <= blk[i];
            end
            for (int i = 0; i < HASH_WORDS; i++) begin
                rv_reg[i] <= hw_reg[i];
            end
        end else if (cmd.round_en) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[BLOCK_WORDS-1] <= sched_next;
            rv_reg[0] <= round_sum;
            rv_reg[1] <= rv_reg[0];
            rv_reg[2] <= rotl30(rv_reg[1]);
            rv_reg[3] <= rv_reg[2];
            rv_reg[4] <= rv_reg[3];
        end
        if (cmd.out_load) begin
            m_word_reg  <= hw_reg[cmd.out_idx];
            m_index_reg <= cmd.out_idx;
            m_last_reg  <= cmd.out_idx == OUT_LAST;
        end
    end

endmodule

/* rtl/sha1_byte_stream_hasher.sv */
// Channel  Direction  Handshake           Word contents
// s_       in         s_valid / s_ready   s_func, s_data_byte
// m_       out        m_valid / m_ready   m_digest_word, m_word_index, m_last_word
//
// A data byte is taken while the block is idle. The byte that fills a 64-byte
// block starts a pass (block load, 80 rounds of the single round unit, chain fold).
// A finish runs one or two such passes, then sends five words.
// Reset is synchronous on aresetn low and restores the initial chain value and zero counts.
// A stalled output holds its word while s_ready stays low until the fifth word is loaded.
module sha1_byte_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);
    import sha1bsh_pkg::*;

    // The controller sequences byte writes, block passes and digest output; the
    // datapath holds the block buffer, chain value, counters and round unit.
    dp_cmd_t    cmd;
    dp_status_t status;

    sha1bsh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The finish passes work on a copy of the chain value, so the running hash
    // is untouched and more bytes may follow a finish.
    sha1bsh_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_data_byte   (s_data_byte),
        .cmd           (cmd),
        .status        (status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last_word   (m_last_word)
    );

endmodule

/* rtl/sha1bsh_chk.sv */
`include "sha1_byte_stream_hasher_assert.svh"

module sha1bsh_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_func,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_digest_word,
    input logic [2:0]  m_word_index,
    input logic        m_last_word
);
    import sha1bsh_pkg::*;

    logic        fin_take;
    logic        mid_take;
    logic        out_stall;
    logic        last_ok;
    logic        step_ok;
    logic [34:0] out_word;
    logic [2:0]  index_inc_reg;

    assign fin_take  = s_valid && s_ready && (s_func == FUNC_FINISH);
    assign mid_take  = m_valid && m_ready && !m_last_word;
    assign out_stall = m_valid && !m_ready;
    assign out_word  = {m_digest_word, m_word_index};
    assign last_ok   = (m_last_word == (m_word_index == OUT_LAST)) && (m_word_index <= OUT_LAST);
    assign step_ok   = m_valid && (m_word_index == index_inc_reg);

    always_ff @(posedge aclk) begin
        index_inc_reg <= m_word_index + 3'd1;
    end

    // Only the fifth word carries the last flag, and no index runs past it.
    `SHA1BSH_ASSERT_NOW(a_last_matches_index, m_valid, last_ok, "last flag off its index")

    // Digest words follow each other without a gap once one is taken.
    `SHA1BSH_ASSERT_NEXT(a_words_in_order, mid_take, step_ok, "digest words out of order")

    // A stalled output word holds.
    `SHA1BSH_ASSERT_NEXT(a_out_hold, out_stall, m_valid && $stable(out_word), "held word changed")

    // A finish starts a block pass, so the next cycle takes no input word.
    `SHA1BSH_ASSERT_NEXT(a_finish_blocks_input, fin_take, !s_ready, "input taken after a finish")

endmodule

bind sha1_byte_stream_hasher sha1bsh_chk u_sha1bsh_chk (.*);

/* tb/tb_sha1_byte_stream_hasher.sv */
`timescale 1ns / 1ps

module tb_sha1_byte_stream_hasher;

    import sha1bsh_pkg::word_t;
    import sha1bsh_pkg::FUNC_ABSORB;
    import sha1bsh_pkg::FUNC_FINISH;

    // Random words offered per traffic phase, and the fixed waits of the run.
    localparam int PHASE_WORDS      = 112;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int TAIL_CYCLES      = 200;

    // One input word as queued for the driver. Besides the payload, each word
    // carries the traffic mix in force while it is offered, a flag that makes
    // the sender wait until every digest word has come back, and a flag that
    // starts a long receiver hold-off when the word goes out.
    typedef struct packed {
        logic       func;
        logic [7:0] data;
        logic [6:0] sender_idle;
        logic [6:0] recv_stall;
        logic       drain;
        logic       hold;
    } in_word_t;

    // One expected output word.
    typedef struct packed {
        word_t      value;
        logic [2:0] index;
        logic       last;
    } digest_word_t;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic        s_func        = FUNC_ABSORB;
    logic [7:0]  s_data_byte   = 8'h00;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_last_word;

    in_word_t     stim_q[$];
    digest_word_t digest_q[$];

    // Shadow of the hasher's running state: chain value (H0 in the top bits),
    // the partly filled block (byte 0 in the top bits), its fill level and
    // the 32-bit count of absorbed bytes.
    logic [159:0] run_chain = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                               32'h10325476, 32'hC3D2E1F0};
    logic [511:0] run_block = '0;
    int           run_fill  = 0;
    logic [31:0]  run_total = '0;

    // Set when the previous rising edge moved an input word.
    logic in_taken = 1'b0;

    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_left      = 0;
    int mismatches     = 0;

    // Generator-side view of the traffic mix and of the block fill level,
    // used only while the word queue is being built.
    int gen_sidle = 0;
    int gen_rstall = 0;
    int gen_fill = 0;

    sha1_byte_stream_hasher u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last_word   (m_last_word)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // One SHA-1 compression of a 64-byte block into a chain value. The
    // schedule is kept as a sixteen-word circular window.
    function automatic logic [159:0] sha1_compress(input logic [159:0] chain,
                                                   input logic [511:0] blk);
        word_t sched [16];
        word_t a, b, c, d, e, f, k, w, sum;
        a = chain[159:128];
        b = chain[127:96];
        c = chain[95:64];
        d = chain[63:32];
        e = chain[31:0];
        for (int t = 0; t < 80; t++) begin
            if (t < 16) begin
                w = blk[511 - 32 * t -: 32];
            end else begin
                w = sched[(t - 3) % 16] ^ sched[(t - 8) % 16] ^ sched[(t - 14) % 16]
                    ^ sched[t % 16];
                w = {w[30:0], w[31]};
            end
            sched[t % 16] = w;
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            sum = {a[26:0], a[31:27]} + f + e + w + k;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = sum;
        end
        return {chain[159:128] + a, chain[127:96] + b, chain[95:64] + c,
                chain[63:32] + d, chain[31:0] + e};
    endfunction

    task automatic queue_word(input logic func, input logic [7:0] data,
                              input logic drain, input logic hold);
        in_word_t w;
        w.func        = func;
        w.data        = data;
        w.sender_idle = 7'(gen_sidle);
        w.recv_stall  = 7'(gen_rstall);
        w.drain       = drain;
        w.hold        = hold;
        stim_q.push_back(w);
        if (func == FUNC_ABSORB) begin
            gen_fill = (gen_fill + 1) % 64;
        end
    endtask

    task automatic note_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $realtime, what);
        mismatches++;
    endtask

    // Driver. At each falling edge, once the current word has gone (or none is
    // up), it either offers the next queued word or leaves the input idle.
    // A word flagged for draining is held back until no digest word is owed,
    // so the block is fully quiet when it arrives. Valid is written at most
    // once per edge, so a word that follows straight on keeps valid high.
    always @(negedge aclk) begin
        in_word_t nxt;
        logic     go;
        go = 1'b0;
        if (aresetn && (!s_valid || in_taken) && stim_q.size() != 0) begin
            recv_stall_pct <= int'(stim_q[0].recv_stall);
            if (!(stim_q[0].drain && digest_q.size() != 0)
                && $urandom_range(99) >= stim_q[0].sender_idle) begin
                go = 1'b1;
            end
        end
        if (go) begin
            nxt = stim_q.pop_front();
            s_valid     <= 1'b1;
            s_func      <= nxt.func;
            s_data_byte <= nxt.data;
            if (nxt.hold) begin
                hold_requests <= hold_requests + 1;
            end
        end else if (in_taken) begin
            s_valid <= 1'b0;
        end
    end

    // Long receiver hold-off. Each request keeps ready low long enough for the
    // first digest word to back up into the block and for the block to stop
    // taking input words behind it.
    always @(posedge aclk) begin
        if (holds_served != hold_requests) begin
            holds_served <= hold_requests;
            hold_left    <= LONG_HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver ready, changed on the falling edge like every other input.
    always @(negedge aclk) begin
        if (!aresetn || hold_left != 0) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor. The output word of this edge is checked first, and only then is
    // the input word of the same edge folded into the shadow state. A finish
    // pads a copy of the state and queues the five digest words it must
    // produce; the running state itself is never touched by a finish.
    always @(posedge aclk) begin
        digest_word_t want;
        digest_word_t ent;
        logic [511:0] pad;
        logic [159:0] h;
        if (aresetn && m_valid && m_ready) begin
            if (digest_q.size() == 0) begin
                note_mismatch($sformatf("digest word %h (index %0d) with none outstanding",
                                        m_digest_word, m_word_index));
            end else begin
                want = digest_q.pop_front();
                if (m_digest_word !== want.value) begin
                    note_mismatch($sformatf("word %0d value %h, expected %h",
                                            want.index, m_digest_word, want.value));
                end
                if (m_word_index !== want.index) begin
                    note_mismatch($sformatf("word index %0d, expected %0d",
                                            m_word_index, want.index));
                end
                if (m_last_word !== want.last) begin
                    note_mismatch($sformatf("last flag %b on word %0d, expected %b",
                                            m_last_word, want.index, want.last));
                end
            end
        end

        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            if (s_func == FUNC_ABSORB) begin
                // A byte goes into the block; the 64th byte compresses it at once.
                run_block[511 - 8 * run_fill -: 8] = s_data_byte;
                run_fill  = run_fill + 1;
                run_total = run_total + 32'd1;
                if (run_fill == 64) begin
                    run_chain = sha1_compress(run_chain, run_block);
                    run_fill  = 0;
                end
            end else begin
                // Only the bytes below the fill level are taken from the
                // buffer; the marker byte and zeros follow. With 56 or more
                // bytes held the length no longer fits, so the padded block is
                // compressed and a second all-zero block carries the length.
                pad = run_block;
                pad[511 - 8 * run_fill -: 8] = 8'h80;
                for (int i = run_fill + 1; i < 64; i++) begin
                    pad[511 - 8 * i -: 8] = 8'h00;
                end
                h = run_chain;
                if (run_fill >= 56) begin
                    h   = sha1_compress(h, pad);
                    pad = '0;
                end
                // The bit length wraps at 32 bits; the four bytes above it stay zero.
                pad[31:0] = run_total << 3;
                h = sha1_compress(h, pad);
                for (int i = 0; i < 5; i++) begin
                    ent.value = h[159 - 32 * i -: 32];
                    ent.index = 3'(i);
                    ent.last  = (i == 4);
                    digest_q.push_back(ent);
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int         phase;
        int         n;
        int         target;
        int         count;
        logic [7:0] b;
        logic       first_finish;

        // Directed words, no idling. A finish on the empty message, a second
        // finish that must give the same digest, the short message "abc", the
        // byte extremes, a finish whose data byte is not zero (it must be
        // ignored), and one finish that starts a long receiver hold-off while
        // more words keep coming behind it.
        queue_word(FUNC_FINISH, 8'hA5, 1'b0, 1'b0);
        queue_word(FUNC_FINISH, 8'h00, 1'b0, 1'b0);
        queue_word(FUNC_ABSORB, 8'h61, 1'b0, 1'b0);
        queue_word(FUNC_ABSORB, 8'h62, 1'b0, 1'b0);
        queue_word(FUNC_ABSORB, 8'h63, 1'b0, 1'b0);
        queue_word(FUNC_FINISH, 8'h00, 1'b0, 1'b0);
        queue_word(FUNC_ABSORB, 8'h00, 1'b0, 1'b0);
        queue_word(FUNC_ABSORB, 8'hFF, 1'b0, 1'b0);
        queue_word(FUNC_FINISH, 8'hFF, 1'b0, 1'b0);
        queue_word(FUNC_FINISH, 8'h5A, 1'b0, 1'b1);
        queue_word(FUNC_ABSORB, 8'h80, 1'b0, 1'b0);
        queue_word(FUNC_ABSORB, 8'h7F, 1'b0, 1'b0);
        queue_word(FUNC_ABSORB, 8'h01, 1'b0, 1'b0);
        queue_word(FUNC_FINISH, 8'h00, 1'b0, 1'b0);

        // Random messages in four traffic mixes: free flowing, a mostly idle
        // sender, a mostly stalling receiver, and light idling on both sides.
        // Each mix opens with a word that waits for the block to drain. The
        // finish points are steered toward the fill levels where padding
        // changes shape: an empty block, exactly 55 bytes (length just fits),
        // 56 through 63 (two padded blocks), plus fully random points. Some
        // messages run through an extra full block before finishing.
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    gen_sidle  = 0;
                    gen_rstall = 0;
                end
                1: begin
                    gen_sidle  = 79;
                    gen_rstall = 0;
                end
                2: begin
                    gen_sidle  = 0;
                    gen_rstall = 79;
                end
                default: begin
                    gen_sidle  = 18;
                    gen_rstall = 18;
                end
            endcase
            queue_word(FUNC_ABSORB, 8'($urandom_range(255)), 1'b1, 1'b0);
            count = 1;
            first_finish = 1'b1;
            while (count < PHASE_WORDS) begin
                case ($urandom_range(7))
                    0: target = 0;
                    1: target = 55;
                    2: target = 56;
                    3: target = 63;
                    4: target = $urandom_range(62, 57);
                    default: target = $urandom_range(63);
                endcase
                n = (target - gen_fill + 64) % 64;
                if (n < 16 && $urandom_range(2) == 0) begin
                    n = n + 64;
                end
                // The last message of a mix is cut short so the mix ends on its word budget.
                if (count + n + 1 > PHASE_WORDS) begin
                    n = PHASE_WORDS - count - 1;
                end
                repeat (n) begin
                    case ($urandom_range(9))
                        0: b = 8'h00;
                        1: b = 8'hFF;
                        default: b = 8'($urandom_range(255));
                    endcase
                    queue_word(FUNC_ABSORB, b, 1'b0, 1'b0);
                end
                // The last mix repeats the long hold-off under random traffic.
                queue_word(FUNC_FINISH, 8'($urandom_range(255)), 1'b0,
                           phase == 3 && first_finish);
                first_finish = 1'b0;
                count = count + n + 1;
            end
        end

        // Reset is held low and released on a falling edge.
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Every queued word must have been taken; the check sits on the rising
        // edge, where the driver's signals are settled.
        do begin
            @(posedge aclk);
        end while (stim_q.size() != 0 || s_valid);
        while (digest_q.size() != 0) begin
            @(negedge aclk);
        end
        // A trailing full block may still be compressing; stray words from it
        // would show up here.
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
